### src/sorted_key_table_assert.svh
// Assertion macros for the sorted key table RTL.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define SKT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Same-cycle implication.
`define SKT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/skt_pkg.sv
// Types, constants and key compare functions for the sorted key table.
`default_nettype none
package skt_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int KEY_BYTES     = 8;
  localparam int KEY_W         = 64;
  localparam int LEN_W         = 4;
  localparam int VALUE_W       = 64;
  localparam int LOC_W         = 63;
  localparam int OP_W          = 2;
  localparam int ENTRY_TOTAL_W = 7;
  localparam int COUNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int GROUP         = 8;
  localparam int NUM_GROUPS    = (TABLE_DEPTH + GROUP - 1) / GROUP;

  localparam logic [VALUE_W-1:0] TOMBSTONE = '1;

  localparam logic [OP_W-1:0] OP_GET    = 2'd0;
  localparam logic [OP_W-1:0] OP_SET    = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_GATHER,
    ST_REDUCE,
    ST_COMMIT
  } skt_state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [LEN_W-1:0]   len;
    logic [VALUE_W-1:0] value;
  } skt_entry_t;

  // Broadcast controls from the sequencer to every cell.
  typedef struct packed {
    logic sample;
    logic commit;
    logic insert;
    logic overwrite;
  } skt_cell_ctrl_t;

  // Ones over the first len bytes, first byte most significant.
  function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      if (LEN_W'(b) < len) begin
        m[KEY_W-1-8*b -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // Returns {entry below probe, entry equal to probe}.
  function automatic logic [1:0] key_compare(input logic [KEY_W-1:0] ek,
                                             input logic [LEN_W-1:0] el,
                                             input logic [KEY_W-1:0] pk,
                                             input logic [LEN_W-1:0] pl);
    logic [LEN_W-1:0] n;
    logic [KEY_W-1:0] m;
    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] b;
    logic             below;
    logic             same;
    n     = (el < pl) ? el : pl;
    m     = key_mask(n);
    a     = ek & m;
    b     = pk & m;
    below = (a < b) || ((a == b) && (el < pl));
    same  = (a == b) && (el == pl);
    return {below, same};
  endfunction

endpackage
`default_nettype wire

### src/skt_if.sv
// Request and response channel interfaces of the sorted key table.
`default_nettype none
interface skt_req_if;
  import skt_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [KEY_W-1:0]   key;
  logic [LEN_W-1:0]   key_len;
  logic [LOC_W-1:0]   location;

  modport source (output valid, operation, key, key_len, location, input ready);
  modport sink   (input valid, operation, key, key_len, location, output ready);
endinterface

interface skt_rsp_if;
  import skt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic signed [VALUE_W-1:0] stored_value;
  logic                     table_full;
  logic [ENTRY_TOTAL_W-1:0] entry_total;

  modport source (output valid, found, stored_value, table_full, entry_total,
                  input ready);
  modport sink   (input valid, found, stored_value, table_full, entry_total,
                  output ready);
endinterface
`default_nettype wire

### src/skt_cell.sv
// One table slot: holds an entry, compares it with the probe, shifts along the chain.
`default_nettype none
module skt_cell
  import skt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  skt_cell_ctrl_t     ctrl,
  input  skt_entry_t         new_entry,
  input  logic               valid,
  input  logic               in_span,
  input  skt_entry_t         prev_entry,
  input  logic               prev_lt,
  output skt_entry_t         entry,
  output logic               lt,
  output logic               eq,
  output logic [VALUE_W-1:0] hit_value
);

  logic [1:0] cmp;

  // compare held entry with probe
  always_comb begin
    cmp = key_compare(entry.key, entry.len, new_entry.key, new_entry.len);
  end

  // flags, valid slots only
  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= 1'b0;
      eq <= 1'b0;
    end else if (ctrl.sample) begin
      lt <= valid && cmp[1];
      eq <= valid && cmp[0];
    end
  end

  // old value of a hit, zero otherwise
  always_ff @(posedge clk) begin
    if (ctrl.sample) begin
      hit_value <= (valid && cmp[0]) ? entry.value : '0;
    end
  end

  // overwrite in place, or take the new entry / neighbour's entry on insert
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      if (ctrl.overwrite && eq) begin
        entry.value <= new_entry.value;
      end else if (ctrl.insert && in_span && !lt) begin
        entry <= prev_lt ? new_entry : prev_entry;
      end
    end
  end

endmodule
`default_nettype wire

### src/skt_collect.sv
// Registered OR stage over one group of cells: hit flag and hit value.
`default_nettype none
module skt_collect
  import skt_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          enable,
  input  logic [GROUP-1:0]              flags,
  input  logic [GROUP-1:0][VALUE_W-1:0] values,
  output logic                          hit,
  output logic [VALUE_W-1:0]            value
);

  logic               hit_next;
  logic [VALUE_W-1:0] value_next;

  // non-hit cells present zero, so a plain OR picks the hit
  always_comb begin
    hit_next   = 1'b0;
    value_next = '0;
    for (int i = 0; i < GROUP; i++) begin
      hit_next   = hit_next | flags[i];
      value_next = value_next | values[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (enable) begin
      hit <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      value <= value_next;
    end
  end

endmodule
`default_nettype wire

### src/sorted_key_table.sv
// Top level of the sorted key table: sequencer, cell chain and hit collection.
// The table keeps up to TABLE_DEPTH entries in ascending key order, one entry
// per cell of a chain. Each request (get, set, delete) goes through these steps
// before its response is valid: the probe is latched, every cell compares its
// entry with the probe in parallel, two registered OR stages gather the hit
// and its old value, and a commit cycle overwrites the hit in place or shifts
// the cells at and above the insertion point up by one, each taking its
// lower neighbour's entry. A new request is taken in the cycle after commit,
// so a request is not taken before the previous one has been committed.
// Commit waits while a previous response is still held in the output
// register. No clearing pass is needed after reset; the cell entries are not
// cleared, only the entry count.
`default_nettype none
`include "sorted_key_table_assert.svh"
module sorted_key_table
  import skt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  skt_req_if.sink    req,
  skt_rsp_if.source  rsp
);

  skt_state_t state;
  skt_state_t state_next;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  skt_entry_t         new_entry;
  logic [OP_W-1:0]    operation;
  logic               found;
  logic [VALUE_W-1:0] old_value;

  logic               is_write;
  logic               out_free;
  logic               table_is_full;
  logic               gather_en;
  logic               reduce_en;
  skt_cell_ctrl_t     ctrl;

  skt_entry_t                entries [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]    lt_vec;
  logic [TABLE_DEPTH-1:0]    eq_vec;
  logic [VALUE_W-1:0]        hit_values [TABLE_DEPTH];

  logic [NUM_GROUPS-1:0][GROUP-1:0]              grp_flags;
  logic [NUM_GROUPS-1:0][GROUP-1:0][VALUE_W-1:0] grp_values;
  logic [NUM_GROUPS-1:0]                         grp_hit;
  logic [VALUE_W-1:0]                            grp_value [NUM_GROUPS];
  logic                                          found_next;
  logic [VALUE_W-1:0]                            old_value_next;

  logic                      rsp_valid;
  logic                      rsp_found;
  logic [VALUE_W-1:0]        rsp_value;
  logic                      rsp_full;
  logic [ENTRY_TOTAL_W-1:0]  rsp_total;

  logic [LEN_W-1:0] len_sat;

  // latch and normalise the probe on acceptance
  always_comb begin
    len_sat = (req.key_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : req.key_len;
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      operation     <= req.operation;
      new_entry.key <= req.key & key_mask(len_sat);
      new_entry.len <= len_sat;
      new_entry.value <= (req.operation == OP_DELETE) ? TOMBSTONE
                                                      : {1'b0, req.location};
    end
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (req.valid) state_next = ST_COMPARE;
      ST_COMPARE: state_next = ST_GATHER;
      ST_GATHER:  state_next = ST_REDUCE;
      ST_REDUCE:  state_next = ST_COMMIT;
      ST_COMMIT:  if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: outputs
  always_comb begin
    req.ready      = 1'b0;
    ctrl.sample    = 1'b0;
    ctrl.commit    = 1'b0;
    ctrl.overwrite = is_write && found;
    ctrl.insert    = is_write && !found && !table_is_full;
    gather_en      = 1'b0;
    reduce_en      = 1'b0;
    unique case (state)
      ST_IDLE:    req.ready   = !rst;
      ST_COMPARE: ctrl.sample = 1'b1;
      ST_GATHER:  gather_en   = 1'b1;
      ST_REDUCE:  reduce_en   = 1'b1;
      ST_COMMIT:  ctrl.commit = out_free;
      default:    req.ready   = 1'b0;
    endcase
  end

  // commit decision
  always_comb begin
    is_write      = (operation == OP_SET) || (operation == OP_DELETE);
    out_free      = !rsp_valid || rsp.ready;
    table_is_full = (count == COUNT_W'(TABLE_DEPTH));
    count_next    = (is_write && !found && !table_is_full) ? count + COUNT_W'(1) : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.commit) begin
      count <= count_next;
    end
  end

  // cell chain
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    skt_entry_t prev_entry;
    logic       prev_lt;
    logic       valid;
    logic       in_span;

    if (i == 0) begin : g_first
      assign prev_entry = new_entry;
      assign prev_lt    = 1'b1;
    end else begin : g_rest
      assign prev_entry = entries[i-1];
      assign prev_lt    = lt_vec[i-1];
    end

    assign valid   = COUNT_W'(i) < count;
    assign in_span = COUNT_W'(i) <= count;

    skt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_entry  (new_entry),
      .valid      (valid),
      .in_span    (in_span),
      .prev_entry (prev_entry),
      .prev_lt    (prev_lt),
      .entry      (entries[i]),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i]),
      .hit_value  (hit_values[i])
    );
  end

  // first OR level: groups of cells, padded with zero
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
    for (genvar j = 0; j < GROUP; j++) begin : g_slot
      if (g * GROUP + j < TABLE_DEPTH) begin : g_used
        assign grp_flags[g][j]  = eq_vec[g*GROUP+j];
        assign grp_values[g][j] = hit_values[g*GROUP+j];
      end else begin : g_pad
        assign grp_flags[g][j]  = 1'b0;
        assign grp_values[g][j] = '0;
      end
    end

    skt_collect u_collect (
      .clk    (clk),
      .rst    (rst),
      .enable (gather_en),
      .flags  (grp_flags[g]),
      .values (grp_values[g]),
      .hit    (grp_hit[g]),
      .value  (grp_value[g])
    );
  end

  // second OR level over the groups
  always_comb begin
    found_next     = 1'b0;
    old_value_next = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      found_next     = found_next | grp_hit[g];
      old_value_next = old_value_next | grp_value[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (reduce_en) begin
      found <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (reduce_en) begin
      old_value <= old_value_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      rsp_found <= found;
      rsp_value <= old_value;
      rsp_full  <= is_write && !found && table_is_full;
      rsp_total <= ENTRY_TOTAL_W'(count_next);
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.found        = rsp_found;
  assign rsp.stored_value = rsp_value;
  assign rsp.table_full   = rsp_full;
  assign rsp.entry_total  = rsp_total;

  // keys are unique, so at most one cell may match
  `SKT_ASSERT_ALWAYS(a_single_hit, $onehot0(eq_vec), "more than one cell matched the probe")
  `SKT_ASSERT_ALWAYS(a_count_bound, count <= COUNT_W'(TABLE_DEPTH), "entry count overflow")
  `SKT_ASSERT_IMPLY(a_full_at_depth, rsp.valid && rsp.table_full,
                    count == COUNT_W'(TABLE_DEPTH), "full flagged below depth")
  `SKT_ASSERT_NEXT(a_insert_counts, ctrl.commit && ctrl.insert,
                   count == $past(count) + COUNT_W'(1), "insert did not bump count")

endmodule
`default_nettype wire

### dv/tb_sorted_key_table.sv
// Self-checking testbench for the sorted key table: directed rows, then random requests.
`timescale 1ns / 100ps
module tb_sorted_key_table;
  import skt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int RANDOM_REQUESTS  = 750;
  localparam int IDLE_LIMIT       = 2000;
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int DRAIN_PAUSE_AT   = 450;
  localparam int TAIL_CYCLES      = 10;

  typedef struct packed {
    logic                     found;
    logic [VALUE_W-1:0]       stored_value;
    logic                     table_full;
    logic [ENTRY_TOTAL_W-1:0] entry_total;
  } lookup_result_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
    logic [LOC_W-1:0] loc;
  } request_t;

  typedef struct {
    request_t       rq;
    bit             typed;
    lookup_result_t want;
  } stim_row_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } known_key_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  skt_req_if req_ch ();
  skt_rsp_if rsp_ch ();

  sorted_key_table u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the table, kept in key order
  logic [KEY_W-1:0]   tbl_key   [TABLE_DEPTH];
  logic [LEN_W-1:0]   tbl_len   [TABLE_DEPTH];
  logic [VALUE_W-1:0] tbl_value [TABLE_DEPTH];
  int                 tbl_count = 0;

  lookup_result_t pending_results[$];
  stim_row_t      directed_rows[$];
  known_key_t     known_keys[$];

  int mismatches = 0;
  int responses  = 0;
  int hit_count  = 0;
  int drop_count = 0;
  int op_count[4] = '{0, 0, 0, 0};

  // Ones over the first n bytes, first byte at the top
  function automatic logic [KEY_W-1:0] byte_mask(input int unsigned n);
    if (n == 0) return '0;
    if (n >= KEY_BYTES) return '1;
    return {KEY_W{1'b1}} << (KEY_W - 8 * n);
  endfunction

  // Sign of (stored entry - probe) under byte order, shorter prefix first
  function automatic int key_order(input int idx, input logic [KEY_W-1:0] k,
                                   input int unsigned len);
    int unsigned      el;
    logic [KEY_W-1:0] m;
    el = tbl_len[idx];
    m  = byte_mask((el < len) ? el : len);
    if ((tbl_key[idx] & m) != (k & m)) return ((tbl_key[idx] & m) < (k & m)) ? -1 : 1;
    if (el == len) return 0;
    return (el < len) ? -1 : 1;
  endfunction

  // Applies one request to the shadow table and returns its response
  function automatic lookup_result_t apply_request(input request_t rq);
    int unsigned        len;
    logic [KEY_W-1:0]   k;
    logic [VALUE_W-1:0] nv;
    int                 pos;
    bit                 hit;
    lookup_result_t     res;
    len = (rq.len > KEY_BYTES) ? KEY_BYTES : rq.len;
    k   = rq.key & byte_mask(len);
    nv  = (rq.op == OP_DELETE) ? TOMBSTONE : {1'b0, rq.loc};
    pos = 0;
    while (pos < tbl_count && key_order(pos, k, len) < 0) pos++;
    hit = (pos < tbl_count) && (key_order(pos, k, len) == 0);
    res = '0;
    res.found = hit;
    if (hit) res.stored_value = tbl_value[pos];
    if (rq.op == OP_SET || rq.op == OP_DELETE) begin
      if (hit) begin
        tbl_value[pos] = nv;
      end else if (tbl_count >= TABLE_DEPTH) begin
        res.table_full = 1'b1;
        drop_count++;
      end else begin
        // shift the upper entries up by one to open the slot
        for (int i = tbl_count; i > pos; i--) begin
          tbl_key[i]   = tbl_key[i-1];
          tbl_len[i]   = tbl_len[i-1];
          tbl_value[i] = tbl_value[i-1];
        end
        tbl_key[pos]   = k;
        tbl_len[pos]   = LEN_W'(len);
        tbl_value[pos] = nv;
        tbl_count++;
      end
    end
    res.entry_total = ENTRY_TOTAL_W'(tbl_count);
    hit_count += hit;
    op_count[rq.op]++;
    return res;
  endfunction

  function automatic void add_row(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                  input logic [LEN_W-1:0] len, input logic [LOC_W-1:0] loc,
                                  input bit typed = 1'b0, input logic found = 1'b0,
                                  input logic [VALUE_W-1:0] value = '0,
                                  input logic full = 1'b0,
                                  input logic [ENTRY_TOTAL_W-1:0] total = '0);
    stim_row_t row;
    row.rq                = '{op: op, key: key, len: len, loc: loc};
    row.typed             = typed;
    row.want.found        = found;
    row.want.stored_value = value;
    row.want.table_full   = full;
    row.want.entry_total  = total;
    directed_rows.push_back(row);
  endfunction

  function automatic void build_directed_rows();
    // empty table, empty key, garbage behind a zero length
    add_row(OP_GET, 64'h0, 4'd0, 63'd0, 1'b1, 1'b0, '0, 1'b0, 7'd0);
    add_row(OP_SET, 64'h0, 4'd0, 63'h123, 1'b1, 1'b0, '0, 1'b0, 7'd1);
    add_row(OP_GET, 64'hA5A5_A5A5_A5A5_A5A5, 4'd0, 63'd0, 1'b1, 1'b1, 64'h123, 1'b0, 7'd1);
    // all-ones key, widest value, oversized length
    add_row(OP_SET, '1, 4'd8, '1, 1'b1, 1'b0, '0, 1'b0, 7'd2);
    add_row(OP_GET, '1, 4'd15, 63'd0, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 7'd2);
    // shorter prefix sorts first; unused bytes masked
    add_row(OP_SET, 64'h41DE_ADBE_EF01_2345, 4'd1, 63'd5);
    add_row(OP_SET, 64'h4100_0000_0000_0000, 4'd2, 63'd6);
    add_row(OP_GET, 64'h41FF_FFFF_FFFF_FFFF, 4'd1, 63'd0);
    add_row(OP_GET, 64'h4100_FFFF_FFFF_FFFF, 4'd2, 63'd0);
    // delete of an absent key inserts a tombstone
    add_row(OP_DELETE, 64'h4200_0000_0000_0000, 4'd1, 63'h777, 1'b1, 1'b0, '0, 1'b0, 7'd5);
    add_row(OP_GET, 64'h4211_2233_4455_6677, 4'd1, 63'd0, 1'b1, 1'b1, TOMBSTONE, 1'b0, 7'd5);
    add_row(OP_DELETE, 64'h4100_0000_0000_0000, 4'd1, 63'd0);
    // unknown operation behaves as a get
    add_row(OP_UNKNOWN, 64'h4200_0000_0000_0000, 4'd1, 63'h55, 1'b1, 1'b1, TOMBSTONE,
            1'b0, 7'd5);
    add_row(OP_UNKNOWN, 64'h4300_0000_0000_0000, 4'd1, 63'd0);
    add_row(OP_SET, 64'h4200_0000_0000_0000, 4'd1, 63'd0, 1'b1, 1'b1, TOMBSTONE, 1'b0, 7'd5);
    add_row(OP_GET, 64'h4200_0000_0000_0000, 4'd1, 63'd0);
    // zero bytes of several lengths, top and bottom bits
    add_row(OP_SET, 64'h0, 4'd1, 63'd9);
    add_row(OP_SET, 64'h0, 4'd8, 63'd10);
    add_row(OP_SET, 64'h8000_0000_0000_0000, 4'd8, 63'd11);
    add_row(OP_SET, 64'h0000_0000_0000_0001, 4'd8, 63'd12);
    add_row(OP_GET, '1, 4'd1, 63'd0);
    add_row(OP_DELETE, '1, 4'd9, 63'd0);
    add_row(OP_GET, '1, 4'd8, 63'd0);
    add_row(OP_SET, 64'h8000_0000_0000_0000, 4'd8, '1);
  endfunction

  // Random request: mostly keys already seen, the rest fresh keys
  function automatic request_t random_request();
    request_t   rq;
    known_key_t pick;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 35)      rq.op = OP_GET;
    else if (r < 65) rq.op = OP_SET;
    else if (r < 92) rq.op = OP_DELETE;
    else             rq.op = OP_UNKNOWN;
    if (known_keys.size() > 0 && $urandom_range(0, 99) < 70) begin
      pick   = known_keys[$urandom_range(0, known_keys.size() - 1)];
      rq.len = (pick.len == KEY_BYTES) ? LEN_W'($urandom_range(KEY_BYTES, 15)) : pick.len;
      rq.key = pick.key | ({$urandom, $urandom} & ~byte_mask(pick.len));
    end else begin
      rq.len = LEN_W'($urandom_range(0, 15));
      if ($urandom_range(0, 1) == 1) begin
        rq.key = {$urandom, $urandom};
      end else begin
        // few byte values so that prefixes collide often
        for (int b = 0; b < KEY_BYTES; b++) begin
          case ($urandom_range(0, 5))
            0: rq.key[KEY_W-1-8*b -: 8] = 8'h00;
            1: rq.key[KEY_W-1-8*b -: 8] = 8'h01;
            2: rq.key[KEY_W-1-8*b -: 8] = 8'h41;
            3: rq.key[KEY_W-1-8*b -: 8] = 8'h80;
            4: rq.key[KEY_W-1-8*b -: 8] = 8'hFE;
            default: rq.key[KEY_W-1-8*b -: 8] = 8'hFF;
          endcase
        end
      end
      pick.len = (rq.len > KEY_BYTES) ? LEN_W'(KEY_BYTES) : rq.len;
      pick.key = rq.key & byte_mask(pick.len);
      known_keys.push_back(pick);
    end
    rq.loc = LOC_W'({$urandom, $urandom});
    return rq;
  endfunction

  // Offers one request after a gap and returns once it is taken
  task automatic send_request(input request_t rq, input int gap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= rq.op;
    req_ch.key       <= rq.key;
    req_ch.key_len   <= rq.len;
    req_ch.location  <= rq.loc;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  function automatic void check_result(input lookup_result_t got);
    lookup_result_t want;
    if (pending_results.size() == 0) begin
      $error("response with no request outstanding");
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      mismatches++;
    end
    if (got.stored_value !== want.stored_value) begin
      $error("stored_value: expected %h, got %h", want.stored_value, got.stored_value);
      mismatches++;
    end
    if (got.table_full !== want.table_full) begin
      $error("table_full: expected %0d, got %0d", want.table_full, got.table_full);
      mismatches++;
    end
    if (got.entry_total !== want.entry_total) begin
      $error("entry_total: expected %0d, got %0d", want.entry_total, got.entry_total);
      mismatches++;
    end
  endfunction

  // Request side and end of run
  initial begin : request_side
    int             gap;
    request_t       rq;
    lookup_result_t res;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_GET;
    req_ch.key       <= '0;
    req_ch.key_len   <= '0;
    req_ch.location  <= '0;
    build_directed_rows();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].rq, $urandom_range(0, 5));
      res = apply_request(directed_rows[i].rq);
      pending_results.push_back(directed_rows[i].typed ? directed_rows[i].want : res);
    end

    for (int idx = 0; idx < RANDOM_REQUESTS; idx++) begin
      // once, let every outstanding response drain before going on
      if (idx == DRAIN_PAUSE_AT) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      gap = ((idx / 60) % 3 == 2) ? 0 : $urandom_range(0, 5);
      rq  = random_request();
      send_request(rq, gap);
      pending_results.push_back(apply_request(rq));
    end
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d requests (%0d get, %0d set, %0d delete, %0d unknown op),",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[OP_GET], op_count[OP_SET], op_count[OP_DELETE], op_count[OP_UNKNOWN]);
    $display("%0d hits, %0d inserts refused on a full table, %0d entries held at the end.",
             hit_count, drop_count, tbl_count);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Response side: random stalls, one long hold-off
  initial begin : response_side
    int             stall;
    lookup_result_t got;
    rsp_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = ((responses / 45) % 3 == 1) ? 0 : $urandom_range(0, 5);
      if (responses == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      got.found        = rsp_ch.found;
      got.stored_value = rsp_ch.stored_value;
      got.table_full   = rsp_ch.table_full;
      got.entry_total  = rsp_ch.entry_total;
      check_result(got);
      responses++;
    end
  end

  // Watchdog on cycles without any request or response moving
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
